@@ rtl/core/boundary_tag_heap_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// Boundary-tag heap allocator assertion macros
// Concurrent assertion shorthands for the allocator top level.
// ----------------------------------------------------------------------------
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_DEFINES_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_DEFINES_SVH

// implication in the same cycle
`define BTH_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator assertion failed");

// implication in the next cycle
`define BTH_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator assertion failed");

`endif

@@ rtl/core/bth_pkg.sv @@
// ----------------------------------------------------------------------------
// Boundary-tag heap allocator package
// Heap geometry, field widths, tag helpers and controller/datapath types.
// ----------------------------------------------------------------------------
package bth_pkg;

   localparam int GRANULE_BYTES  = 32;
   localparam int HEADER_BYTES   = 20;
   localparam int FOOTER_BYTES   = 8;
   localparam int HEAP_MAX_BYTES = 262144;
   localparam int INIT_BYTES     = 32768;
   localparam int PAGE_BYTES     = 4096;

   localparam int MAX_GRANULES  = HEAP_MAX_BYTES / GRANULE_BYTES;
   localparam int GRAN_SHIFT    = $clog2(GRANULE_BYTES);
   localparam int IDX_W         = $clog2(MAX_GRANULES);
   localparam int CNT_W         = IDX_W + 1;
   localparam int TAG_W         = CNT_W + 2;
   localparam int PAGE_GRANULES = PAGE_BYTES / GRANULE_BYTES;
   localparam int PAGE_SHIFT    = $clog2(PAGE_GRANULES);
   localparam int INIT_ROUND    = ((INIT_BYTES + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
   localparam int INIT_CLIP     = (INIT_ROUND > HEAP_MAX_BYTES) ? HEAP_MAX_BYTES : INIT_ROUND;
   localparam int INIT_GRANULES = INIT_CLIP / GRANULE_BYTES;

   localparam int KIND_W   = 2;
   localparam int REQ_W    = 19;
   localparam int ADDR_W   = 18;
   localparam int STATUS_W = 3;
   localparam int LIMIT_W  = 7;
   localparam int NEED_W   = REQ_W + 1 - GRAN_SHIFT;
   localparam int SUM_W    = 32;
   localparam int OVERHEAD = HEADER_BYTES + FOOTER_BYTES + GRANULE_BYTES - 1;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_CHECK = 2'd2,
      KIND_NOP   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_NOSPACE    = 3'd1,
      ST_MISALIGNED = 3'd2,
      ST_OUTSIDE    = 3'd3,
      ST_FREED      = 3'd4,
      ST_NOTBLOCK   = 3'd5
   } status_code_type;

   typedef enum logic [4:0] {
      CMD_NONE       = 5'd0,
      CMD_CLEAR      = 5'd1,
      CMD_LOAD       = 5'd2,
      CMD_WALK_START = 5'd3,
      CMD_RD_G       = 5'd4,
      CMD_WALK_EVAL  = 5'd5,
      CMD_TAKE_BEST  = 5'd6,
      CMD_GROW       = 5'd7,
      CMD_P_INIT     = 5'd8,
      CMD_RD_P       = 5'd9,
      CMD_P_DEC      = 5'd10,
      CMD_PREV_A     = 5'd11,
      CMD_PREV_FIX   = 5'd12,
      CMD_RD_N       = 5'd13,
      CMD_NEXT_A     = 5'd14,
      CMD_NEXT_FIX   = 5'd15,
      CMD_SPLIT      = 5'd16,
      CMD_USE        = 5'd17,
      CMD_RD_H       = 5'd18,
      CMD_FREE_H     = 5'd19,
      CMD_RESP       = 5'd20
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type      op;
      status_code_type code;
   } cmd_type;

   typedef struct packed {
      logic     clr_done;
      kind_type kind;
      logic     need_big;
      logic     misaligned;
      logic     outside;
      logic     notblk_pre;
      logic     g_ge_end;
      logic     sz_zero;
      logic     hit_stop;
      logic     found;
      logic     grow_ok;
      logic     mg_zero;
      logic     p_zero;
      logic     n_lt_end;
      logic     rd_start;
      logic     rd_free;
      logic     split_need;
      logic     out_busy;
   } stat_type;

   function automatic logic [TAG_W-1:0] make_tag(input logic used, input logic [CNT_W-1:0] size);
      make_tag = {1'b1, used, size};
   endfunction

endpackage

@@ rtl/core/bth_datapath.sv @@
// ----------------------------------------------------------------------------
// Boundary-tag heap allocator datapath
// Tag memory, heap end, walk and merge registers and the result register.
// ----------------------------------------------------------------------------
module bth_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  bth_pkg::cmd_type               cmd,
   output bth_pkg::stat_type              stat,
   input  logic                           fit_mode,
   input  logic [bth_pkg::LIMIT_W-1:0]    limit_pages,
   input  logic [bth_pkg::KIND_W-1:0]     in_kind,
   input  logic [bth_pkg::REQ_W-1:0]      in_request_bytes,
   input  logic [bth_pkg::ADDR_W-1:0]     in_address,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [bth_pkg::ADDR_W-1:0]     rsp_data_address,
   output logic [bth_pkg::STATUS_W-1:0]   rsp_status
);
   import bth_pkg::*;

   logic [TAG_W-1:0] tag_mem [MAX_GRANULES];
   logic [TAG_W-1:0] rdata_ff;

   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [NEED_W-1:0]   need_ff, need_in;
   logic [CNT_W-1:0]    g_ff, g_in;
   logic [CNT_W-1:0]    best_ff, best_in;
   logic [CNT_W-1:0]    bsize_ff, bsize_in;
   logic                found_ff, found_in;
   logic [CNT_W-1:0]    mg_ff, mg_in;
   logic [CNT_W-1:0]    msz_ff, msz_in;
   logic [IDX_W-1:0]    p_ff, p_in;
   logic [CNT_W-1:0]    t_ff, t_in;
   logic [CNT_W-1:0]    heap_end_ff, heap_end_in;
   logic [CNT_W-1:0]    clr_ff, clr_in;
   logic [ADDR_W-1:0]   res_data_ff, res_data_in;
   logic                out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0]   out_data_ff, out_data_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;

   logic [CNT_W-1:0]        rsize;
   logic [CNT_W-1:0]        n_idx;
   logic [ADDR_W-1:0]       head;
   logic [ADDR_W-GRAN_SHIFT-1:0] head_g;
   logic [SUM_W-1:0]        grow_cnt;
   logic [SUM_W-1:0]        limg_raw;
   logic [SUM_W-1:0]        limg;
   logic [SUM_W-1:0]        end_bytes;
   logic                    hit;
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_wa;
   logic [TAG_W-1:0]        mem_wd;
   logic                    mem_re;
   logic [IDX_W-1:0]        mem_ra;

   assign rsize     = rdata_ff[CNT_W-1:0];
   assign n_idx     = mg_ff + msz_ff;
   assign head      = addr_ff - ADDR_W'(HEADER_BYTES);
   assign head_g    = head[ADDR_W-1:GRAN_SHIFT];
   assign grow_cnt  = ((SUM_W'(need_ff) + SUM_W'(PAGE_GRANULES - 1)) >> PAGE_SHIFT) << PAGE_SHIFT;
   assign limg_raw  = SUM_W'(limit_pages) << PAGE_SHIFT;
   assign limg      = (limg_raw > SUM_W'(MAX_GRANULES)) ? SUM_W'(MAX_GRANULES) : limg_raw;
   assign end_bytes = SUM_W'(heap_end_ff) << GRAN_SHIFT;
   assign hit       = stat.rd_free && (SUM_W'(rsize) >= SUM_W'(need_ff));

   always_comb begin
      stat.clr_done   = clr_ff[CNT_W-1];
      stat.kind       = kind_type'(kind_ff);
      stat.need_big   = SUM_W'(need_ff) > SUM_W'(MAX_GRANULES);
      stat.misaligned = addr_ff[1:0] != 2'd0;
      stat.outside    = SUM_W'(addr_ff) > end_bytes;
      stat.notblk_pre = (SUM_W'(addr_ff) < SUM_W'(HEADER_BYTES))
                        || (head[GRAN_SHIFT-1:0] != '0)
                        || (SUM_W'(head_g) >= SUM_W'(heap_end_ff));
      stat.g_ge_end   = g_ff >= heap_end_ff;
      stat.sz_zero    = rsize == '0;
      stat.rd_start   = rdata_ff[TAG_W-1];
      stat.rd_free    = rdata_ff[TAG_W-1] && !rdata_ff[TAG_W-2];
      stat.hit_stop   = hit && ((SUM_W'(rsize) == SUM_W'(need_ff)) || fit_mode);
      stat.found      = found_ff;
      stat.grow_ok    = (SUM_W'(heap_end_ff) + grow_cnt) <= limg;
      stat.mg_zero    = mg_ff == '0;
      stat.p_zero     = p_ff == '0;
      stat.n_lt_end   = n_idx < heap_end_ff;
      stat.split_need = SUM_W'(msz_ff) > SUM_W'(need_ff);
      stat.out_busy   = out_valid_ff && !rsp_tready;
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = '0;
      mem_re = 1'b0;
      mem_ra = '0;
      case (cmd.op)
         CMD_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff[IDX_W-1:0];
            mem_wd = (clr_ff == '0) ? make_tag(1'b0, CNT_W'(INIT_GRANULES)) : '0;
         end
         CMD_GROW: begin
            mem_we = 1'b1;
            mem_wa = heap_end_ff[IDX_W-1:0];
            mem_wd = make_tag(1'b0, grow_cnt[CNT_W-1:0]);
         end
         CMD_PREV_A: begin
            mem_we = 1'b1;
            mem_wa = mg_ff[IDX_W-1:0];
         end
         CMD_PREV_FIX: begin
            mem_we = 1'b1;
            mem_wa = p_ff;
            mem_wd = make_tag(1'b0, msz_ff + t_ff);
         end
         CMD_NEXT_A: begin
            mem_we = 1'b1;
            mem_wa = n_idx[IDX_W-1:0];
         end
         CMD_NEXT_FIX: begin
            mem_we = 1'b1;
            mem_wa = mg_ff[IDX_W-1:0];
            mem_wd = make_tag(1'b0, msz_ff + t_ff);
         end
         CMD_SPLIT: begin
            mem_we = 1'b1;
            mem_wa = IDX_W'(mg_ff + CNT_W'(need_ff));
            mem_wd = make_tag(1'b0, msz_ff - CNT_W'(need_ff));
         end
         CMD_USE: begin
            mem_we = 1'b1;
            mem_wa = mg_ff[IDX_W-1:0];
            mem_wd = make_tag(1'b1, CNT_W'(need_ff));
         end
         CMD_FREE_H: begin
            mem_we = 1'b1;
            mem_wa = IDX_W'(head_g);
            mem_wd = make_tag(1'b0, rsize);
         end
         CMD_RD_G: begin
            mem_re = 1'b1;
            mem_ra = g_ff[IDX_W-1:0];
         end
         CMD_RD_P: begin
            mem_re = 1'b1;
            mem_ra = p_ff;
         end
         CMD_RD_N: begin
            mem_re = 1'b1;
            mem_ra = n_idx[IDX_W-1:0];
         end
         CMD_RD_H: begin
            mem_re = 1'b1;
            mem_ra = IDX_W'(head_g);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rdata_ff <= tag_mem[mem_ra];
      end
   end

   always_comb begin
      kind_in       = kind_ff;
      addr_in       = addr_ff;
      need_in       = need_ff;
      g_in          = g_ff;
      best_in       = best_ff;
      bsize_in      = bsize_ff;
      found_in      = found_ff;
      mg_in         = mg_ff;
      msz_in        = msz_ff;
      p_in          = p_ff;
      t_in          = t_ff;
      heap_end_in   = heap_end_ff;
      clr_in        = clr_ff;
      res_data_in   = res_data_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_data_in   = out_data_ff;
      out_status_in = out_status_ff;
      case (cmd.op)
         CMD_CLEAR: begin
            clr_in = clr_ff + CNT_W'(1);
         end
         CMD_LOAD: begin
            kind_in     = in_kind;
            addr_in     = in_address;
            need_in     = NEED_W'((SUM_W'(in_request_bytes) + SUM_W'(OVERHEAD)) >> GRAN_SHIFT);
            res_data_in = '0;
         end
         CMD_WALK_START: begin
            g_in     = '0;
            found_in = 1'b0;
         end
         CMD_WALK_EVAL: begin
            if (hit && (stat.hit_stop || !found_ff || (rsize < bsize_ff))) begin
               best_in  = g_ff;
               bsize_in = rsize;
               found_in = 1'b1;
            end
            g_in = g_ff + rsize;
         end
         CMD_TAKE_BEST: begin
            mg_in  = best_ff;
            msz_in = bsize_ff;
         end
         CMD_GROW: begin
            mg_in       = heap_end_ff;
            msz_in      = grow_cnt[CNT_W-1:0];
            heap_end_in = heap_end_ff + grow_cnt[CNT_W-1:0];
         end
         CMD_P_INIT: begin
            p_in = IDX_W'(mg_ff - CNT_W'(1));
         end
         CMD_P_DEC: begin
            p_in = p_ff - IDX_W'(1);
         end
         CMD_PREV_A: begin
            t_in = rsize;
         end
         CMD_PREV_FIX: begin
            msz_in = msz_ff + t_ff;
            mg_in  = CNT_W'(p_ff);
         end
         CMD_NEXT_A: begin
            t_in = rsize;
         end
         CMD_NEXT_FIX: begin
            msz_in = msz_ff + t_ff;
         end
         CMD_USE: begin
            res_data_in = ADDR_W'(SUM_W'(mg_ff[IDX_W-1:0]) << GRAN_SHIFT)
                          + ADDR_W'(HEADER_BYTES);
         end
         CMD_FREE_H: begin
            mg_in  = CNT_W'(head_g);
            msz_in = rsize;
         end
         CMD_RESP: begin
            out_valid_in  = 1'b1;
            out_data_in   = res_data_ff;
            out_status_in = cmd.code;
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         heap_end_ff  <= CNT_W'(INIT_GRANULES);
         out_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         heap_end_ff  <= heap_end_in;
         out_valid_ff <= out_valid_in;
         found_ff     <= found_in;
      end
      kind_ff       <= kind_in;
      addr_ff       <= addr_in;
      need_ff       <= need_in;
      g_ff          <= g_in;
      best_ff       <= best_in;
      bsize_ff      <= bsize_in;
      mg_ff         <= mg_in;
      msz_ff        <= msz_in;
      p_ff          <= p_in;
      t_ff          <= t_in;
      res_data_ff   <= res_data_in;
      out_data_ff   <= out_data_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid       = out_valid_ff;
   assign rsp_data_address = out_data_ff;
   assign rsp_status       = out_status_ff;

endmodule

@@ rtl/core/bth_ctrl.sv @@
// ----------------------------------------------------------------------------
// Boundary-tag heap allocator controller
// Sequences clearing, block walk, heap growth, merge, split and response.
// ----------------------------------------------------------------------------
module bth_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  bth_pkg::stat_type  stat,
   output bth_pkg::cmd_type   cmd
);
   import bth_pkg::*;

   typedef enum logic [16:0] {
      S_CLEAR     = 17'h00001,
      S_IDLE      = 17'h00002,
      S_DECODE    = 17'h00004,
      S_WALK_CHK  = 17'h00008,
      S_WALK_EVAL = 17'h00010,
      S_POST_WALK = 17'h00020,
      S_MERGE     = 17'h00040,
      S_PREV_RD   = 17'h00080,
      S_PREV_EVAL = 17'h00100,
      S_PREV_FIX  = 17'h00200,
      S_NEXT_CHK  = 17'h00400,
      S_NEXT_EVAL = 17'h00800,
      S_NEXT_FIX  = 17'h01000,
      S_SPLIT     = 17'h02000,
      S_USE       = 17'h04000,
      S_HEAD_EVAL = 17'h08000,
      S_RESP      = 17'h10000
   } state_type;

   state_type       state_ff, state_in;
   status_code_type code_ff, code_in;
   state_type       merge_exit;

   assign merge_exit = (stat.kind == KIND_ALLOC) ? S_SPLIT : S_RESP;
   assign req_tready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd.op   = CMD_NONE;
      cmd.code = code_ff;
      case (state_ff)
         S_CLEAR: begin
            if (stat.clr_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.op = CMD_CLEAR;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = CMD_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            code_in  = ST_OK;
            state_in = S_RESP;
            case (stat.kind)
               KIND_ALLOC: begin
                  if (stat.need_big) begin
                     code_in = ST_NOSPACE;
                  end else begin
                     cmd.op   = CMD_WALK_START;
                     state_in = S_WALK_CHK;
                  end
               end
               KIND_FREE: begin
                  if (stat.misaligned) begin
                     code_in = ST_MISALIGNED;
                  end else if (stat.outside) begin
                     code_in = ST_OUTSIDE;
                  end else if (stat.notblk_pre) begin
                     code_in = ST_NOTBLOCK;
                  end else begin
                     cmd.op   = CMD_RD_H;
                     state_in = S_HEAD_EVAL;
                  end
               end
               KIND_CHECK: begin
                  if (stat.outside) begin
                     code_in = ST_OUTSIDE;
                  end else if (stat.misaligned) begin
                     code_in = ST_MISALIGNED;
                  end else if (stat.notblk_pre) begin
                     code_in = ST_NOTBLOCK;
                  end else begin
                     cmd.op   = CMD_RD_H;
                     state_in = S_HEAD_EVAL;
                  end
               end
               default: begin
                  code_in = ST_OK;
               end
            endcase
         end
         S_WALK_CHK: begin
            if (stat.g_ge_end) begin
               state_in = S_POST_WALK;
            end else begin
               cmd.op   = CMD_RD_G;
               state_in = S_WALK_EVAL;
            end
         end
         S_WALK_EVAL: begin
            cmd.op   = CMD_WALK_EVAL;
            state_in = (stat.sz_zero || stat.hit_stop) ? S_POST_WALK : S_WALK_CHK;
         end
         S_POST_WALK: begin
            if (stat.found) begin
               cmd.op   = CMD_TAKE_BEST;
               state_in = S_SPLIT;
            end else if (stat.grow_ok) begin
               cmd.op   = CMD_GROW;
               state_in = S_MERGE;
            end else begin
               code_in  = ST_NOSPACE;
               state_in = S_RESP;
            end
         end
         S_MERGE: begin
            if (stat.mg_zero) begin
               state_in = S_NEXT_CHK;
            end else begin
               cmd.op   = CMD_P_INIT;
               state_in = S_PREV_RD;
            end
         end
         S_PREV_RD: begin
            cmd.op   = CMD_RD_P;
            state_in = S_PREV_EVAL;
         end
         S_PREV_EVAL: begin
            if (stat.rd_start) begin
               if (stat.rd_free) begin
                  cmd.op   = CMD_PREV_A;
                  state_in = S_PREV_FIX;
               end else begin
                  state_in = S_NEXT_CHK;
               end
            end else if (stat.p_zero) begin
               state_in = S_NEXT_CHK;
            end else begin
               cmd.op   = CMD_P_DEC;
               state_in = S_PREV_RD;
            end
         end
         S_PREV_FIX: begin
            cmd.op   = CMD_PREV_FIX;
            state_in = S_NEXT_CHK;
         end
         S_NEXT_CHK: begin
            code_in = ST_OK;
            if (stat.n_lt_end) begin
               cmd.op   = CMD_RD_N;
               state_in = S_NEXT_EVAL;
            end else begin
               state_in = merge_exit;
            end
         end
         S_NEXT_EVAL: begin
            if (stat.rd_free) begin
               cmd.op   = CMD_NEXT_A;
               state_in = S_NEXT_FIX;
            end else begin
               state_in = merge_exit;
            end
         end
         S_NEXT_FIX: begin
            cmd.op   = CMD_NEXT_FIX;
            state_in = merge_exit;
         end
         S_SPLIT: begin
            if (stat.split_need) begin
               cmd.op = CMD_SPLIT;
            end
            state_in = S_USE;
         end
         S_USE: begin
            cmd.op   = CMD_USE;
            code_in  = ST_OK;
            state_in = S_RESP;
         end
         S_HEAD_EVAL: begin
            state_in = S_RESP;
            if (!stat.rd_start) begin
               code_in = ST_NOTBLOCK;
            end else if (stat.kind == KIND_CHECK) begin
               code_in = ST_OK;
            end else if (stat.rd_free) begin
               code_in = ST_FREED;
            end else begin
               cmd.op   = CMD_FREE_H;
               state_in = S_MERGE;
            end
         end
         S_RESP: begin
            if (!stat.out_busy) begin
               cmd.op   = CMD_RESP;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
      code_ff <= code_in;
   end

endmodule

@@ rtl/core/boundary_tag_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// Boundary-tag heap allocator
// Allocate, free and check requests over a granule-tagged heap.
// ----------------------------------------------------------------------------
// After reset the tag memory is cleared one entry a cycle, and no request item
// is taken until that pass ends; register writes are taken at any time. One
// item is worked at a time. An allocate walks the blocks in address order over
// the single-port tag memory, plus merge and split steps; when the heap grows
// or a free merges, granules are scanned backward to find the block below. A
// free that releases a block adds the backward scan and the merge. The result
// register lets the next item enter while a result waits.
`include "boundary_tag_heap_allocator_defines.svh"

module boundary_tag_heap_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [18:0] request_bytes, [36:19] address, [39:37] zero
   input  logic [bth_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] kind
   input  logic [bth_pkg::KIND_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [17:0] data_address, [20:18] status, [23:21] zero
   output logic [bth_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bth_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bth_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bth_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import bth_pkg::*;

   logic               fit_mode_ff, fit_mode_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               csr_wr;
   cmd_type            dp_cmd;
   stat_type           dp_stat;
   logic [ADDR_W-1:0]   rsp_addr;
   logic [STATUS_W-1:0] rsp_stat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      fit_mode_in = fit_mode_ff;
      limit_in    = limit_ff;
      if (csr_wr) begin
         if (csr_paddr[2]) begin
            limit_in = csr_pwdata[LIMIT_W-1:0];
         end else begin
            fit_mode_in = csr_pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff <= 1'b0;
         limit_ff    <= LIMIT_W'(64);
      end else begin
         fit_mode_ff <= fit_mode_in;
         limit_ff    <= limit_in;
      end
   end

   assign csr_prdata = csr_paddr[2] ? CSR_DATA_W'(limit_ff) : CSR_DATA_W'(fit_mode_ff);

   bth_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (dp_stat),
      .cmd        (dp_cmd)
   );

   bth_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .stat             (dp_stat),
      .fit_mode         (fit_mode_ff),
      .limit_pages      (limit_ff),
      .in_kind          (req_tuser),
      .in_request_bytes (req_tdata[REQ_W-1:0]),
      .in_address       (req_tdata[REQ_W+ADDR_W-1:REQ_W]),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_data_address (rsp_addr),
      .rsp_status       (rsp_stat)
   );

   assign rsp_tdata = {(RSP_DATA_W - ADDR_W - STATUS_W)'(0), rsp_stat, rsp_addr};

   `BTH_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `BTH_ASSERT_IMP(a_no_accept_in_clear, clock, reset, !dp_stat.clr_done, !req_tready)
   `BTH_ASSERT_IMP(a_resp_slot_free, clock, reset, dp_cmd.op == CMD_RESP, !rsp_tvalid || rsp_tready)

endmodule
